// ===== sv/rpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rpa_pkg
// shared types, constants and codes of the page allocator
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int FRAME_COUNT = 32768;
	localparam int COUNT_BITS  = 8;
	localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
	localparam int DEPTH_BITS  = FRAME_BITS + 1;
	localparam int OUT_COUNT_BITS = 8;
	localparam int CFG_IDX_BITS = 2;

	typedef logic [FRAME_BITS-1:0]     frame_t;
	typedef logic [DEPTH_BITS-1:0]     depth_t;
	typedef logic [COUNT_BITS-1:0]     count_t;
	typedef logic [OUT_COUNT_BITS-1:0] out_count_t;
	typedef logic [CFG_IDX_BITS-1:0]   cfg_idx_t;

	localparam frame_t LOW_FRAME_RESET  = frame_t'(0);
	localparam frame_t HIGH_FRAME_RESET = frame_t'(32767);
	localparam count_t COUNT_MAX        = '1;
	localparam depth_t DEPTH_FULL       = depth_t'(FRAME_COUNT);

	localparam cfg_idx_t REG_LOW_FRAME  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_HIGH_FRAME = cfg_idx_t'(1);

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_ADDREF = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OOM         = 3'd1,
		ST_RANGE       = 3'd2,
		ST_REFERENCED  = 3'd3,
		ST_SATURATED   = 3'd4,
		ST_DOUBLE_FREE = 3'd5
	} status_t;

	typedef struct packed {
		logic   re;
		frame_t raddr;
		logic   we;
		frame_t waddr;
		count_t wdata;
	} cnt_req_t;

	typedef struct packed {
		logic   re;
		frame_t raddr;
		logic   we;
		frame_t waddr;
		frame_t wdata;
	} stk_req_t;

endpackage

// ===== sv/rpa_count_mem.sv =====
// ----------------------------------------------------------------------------
// rpa_count_mem
// per-frame reference count memory, registered read, zeroed by a sweep
// after reset
// ----------------------------------------------------------------------------
module rpa_count_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  rpa_pkg::cnt_req_t req,
	output rpa_pkg::count_t   rdata,
	output logic              clr_busy
);
	import rpa_pkg::*;

	count_t mem [FRAME_COUNT];
	count_t rdata_q;
	frame_t clr_addr_q;
	logic   clr_busy_q;

	logic   we;
	frame_t waddr;
	count_t wdata;

	always_comb begin
		if (clr_busy_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = req.we;
			waddr = req.waddr;
			wdata = req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == frame_t'(FRAME_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

// ===== sv/rpa_stack_mem.sv =====
// ----------------------------------------------------------------------------
// rpa_stack_mem
// free frame stack memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rpa_stack_mem (
	input  logic              clk,
	input  rpa_pkg::stk_req_t req,
	output rpa_pkg::frame_t   rdata
);
	import rpa_pkg::*;

	frame_t mem [FRAME_COUNT];
	frame_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpa_ctrl
// request sequencer: issues memory reads, then updates counts and stack
// and loads the result register
// ----------------------------------------------------------------------------
module rpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rpa_pkg::mode_t       mode,
	input  rpa_pkg::frame_t      frame,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rpa_pkg::frame_t      result_frame,
	output rpa_pkg::out_count_t  ref_count,
	output rpa_pkg::status_t     status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rpa_pkg::cfg_idx_t    cfg_index,
	input  rpa_pkg::frame_t      cfg_data,
	output rpa_pkg::cnt_req_t    cnt_req,
	input  rpa_pkg::count_t      cnt_rdata,
	input  logic                 clr_busy,
	output rpa_pkg::stk_req_t    stk_req,
	input  rpa_pkg::frame_t      stk_rdata
);
	import rpa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	mode_t  mode_q;
	frame_t frame_q;
	frame_t low_frame_q;
	frame_t high_frame_q;
	depth_t stack_depth_q;
	depth_t fresh_next_q;

	logic       out_valid_q;
	frame_t     result_frame_q;
	out_count_t ref_count_q;
	status_t    status_q;

	logic    accept;
	logic    finish;
	depth_t  depth_m1;
	depth_t  fresh_m1;
	logic    in_rng;
	count_t  cnt_dec;
	count_t  cnt_inc;

	frame_t  res_frame;
	count_t  res_count;
	status_t res_status;
	logic    pop;
	logic    take_fresh;
	logic    push;

	assign in_ready  = (state_q == S_IDLE) && !clr_busy;
	assign accept    = in_valid && in_ready;
	assign finish    = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	assign depth_m1 = stack_depth_q - 1'b1;
	assign fresh_m1 = fresh_next_q - 1'b1;
	assign in_rng   = (frame_q >= low_frame_q) && (frame_q <= high_frame_q);
	assign cnt_dec  = cnt_rdata - 1'b1;
	assign cnt_inc  = cnt_rdata + 1'b1;

	always_comb begin
		res_frame  = frame_q;
		res_count  = '0;
		res_status = ST_OK;
		pop        = 1'b0;
		take_fresh = 1'b0;
		push       = 1'b0;
		// count read goes out with the transfer
		cnt_req.re    = accept;
		cnt_req.raddr = frame;
		cnt_req.we    = 1'b0;
		cnt_req.waddr = frame_q;
		cnt_req.wdata = '0;
		unique case (mode_q)
			MODE_ALLOC: begin
				if (stack_depth_q != '0) begin
					pop        = 1'b1;
					res_frame  = stk_rdata;
					res_count  = count_t'(1);
					cnt_req.we = 1'b1;
				end else if (fresh_next_q > {1'b0, low_frame_q}) begin
					take_fresh = 1'b1;
					res_frame  = fresh_m1[FRAME_BITS-1:0];
					res_count  = count_t'(1);
					cnt_req.we = 1'b1;
				end else begin
					res_frame  = '0;
					res_status = ST_OOM;
				end
				cnt_req.waddr = res_frame;
				cnt_req.wdata = count_t'(1);
			end
			MODE_FREE: begin
				if (!in_rng) begin
					res_status = ST_RANGE;
				end else if (cnt_rdata == '0) begin
					res_status = ST_DOUBLE_FREE;
				end else begin
					cnt_req.we    = 1'b1;
					cnt_req.wdata = cnt_dec;
					res_count     = cnt_dec;
					if (cnt_dec != '0) begin
						res_status = ST_REFERENCED;
					end else begin
						push = (stack_depth_q != DEPTH_FULL);
					end
				end
			end
			MODE_ADDREF: begin
				if (!in_rng) begin
					res_status = ST_RANGE;
				end else if (cnt_rdata == COUNT_MAX) begin
					res_count  = cnt_rdata;
					res_status = ST_SATURATED;
				end else begin
					cnt_req.we    = 1'b1;
					cnt_req.wdata = cnt_inc;
					res_count     = cnt_inc;
				end
			end
			MODE_QUERY: begin
				if (!in_rng) begin
					res_status = ST_RANGE;
				end else begin
					res_count = cnt_rdata;
				end
			end
		endcase
		cnt_req.we = cnt_req.we && finish;
	end

	// stack top read goes out with the transfer
	assign stk_req.re    = accept;
	assign stk_req.raddr = depth_m1[FRAME_BITS-1:0];
	assign stk_req.we    = push && finish;
	assign stk_req.waddr = stack_depth_q[FRAME_BITS-1:0];
	assign stk_req.wdata = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			low_frame_q   <= LOW_FRAME_RESET;
			high_frame_q  <= HIGH_FRAME_RESET;
			stack_depth_q <= '0;
			fresh_next_q  <= depth_t'(HIGH_FRAME_RESET) + 1'b1;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						if (pop) begin
							stack_depth_q <= depth_m1;
						end
						if (push) begin
							stack_depth_q <= stack_depth_q + 1'b1;
						end
						if (take_fresh) begin
							fresh_next_q <= fresh_m1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LOW_FRAME: begin
						low_frame_q <= cfg_data;
					end
					REG_HIGH_FRAME: begin
						high_frame_q <= cfg_data;
						fresh_next_q <= depth_t'(cfg_data) + 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			frame_q <= frame;
		end
		if (finish) begin
			result_frame_q <= res_frame;
			ref_count_q    <= out_count_t'(res_count);
			status_q       <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_frame = result_frame_q;
	assign ref_count    = ref_count_q;
	assign status       = status_q;

endmodule

// ===== sv/refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// page frame allocator with a lifo free stack and per-frame reference counts
// ----------------------------------------------------------------------------
// sequence: a request is taken in S_IDLE and executed in S_EXEC, which loads
//   the result register and raises out_valid once any earlier result is taken
// a new request is taken only after the previous one has left S_EXEC, as the
//   count and stack memories are read and then written back for each request
// reset: counts are zeroed by a sweep over all 32768 frames (FRAME_COUNT), with
//   in_ready low; configuration writes are taken throughout
module refcounted_page_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rpa_pkg::mode_t      mode,
	input  rpa_pkg::frame_t     frame,
	output logic                out_valid,
	input  logic                out_ready,
	output rpa_pkg::frame_t     result_frame,
	output rpa_pkg::out_count_t ref_count,
	output rpa_pkg::status_t    status,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rpa_pkg::cfg_idx_t   cfg_index,
	input  rpa_pkg::frame_t     cfg_data
);
	import rpa_pkg::*;

	cnt_req_t cnt_req;
	count_t   cnt_rdata;
	logic     clr_busy;
	stk_req_t stk_req;
	frame_t   stk_rdata;

	rpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.frame        (frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_frame (result_frame),
		.ref_count    (ref_count),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cnt_req      (cnt_req),
		.cnt_rdata    (cnt_rdata),
		.clr_busy     (clr_busy),
		.stk_req      (stk_req),
		.stk_rdata    (stk_rdata)
	);

	rpa_count_mem u_count_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (cnt_req),
		.rdata    (cnt_rdata),
		.clr_busy (clr_busy)
	);

	rpa_stack_mem u_stack_mem (
		.clk   (clk),
		.req   (stk_req),
		.rdata (stk_rdata)
	);

endmodule

// ===== bench/tb_refcounted_page_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator
// self-checking bench for the reference-counted page frame allocator
// ----------------------------------------------------------------------------
// A directed table covers reset values, range limits, double free, count
// saturation, out of memory, a write to an unused register index and the
// handout of a popped frame outside the window. Random phases then sweep
// several frame windows, the extremes among them. Every result is
// compared against the table or an in-bench allocator model. Requests
// and results idle and stall at random.
// ----------------------------------------------------------------------------
module tb_refcounted_page_allocator;
	import rpa_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 160;
	localparam int RECENT_MAX  = 48;
	localparam cfg_idx_t REG_SPARE = cfg_idx_t'(3);

	typedef enum logic {
		ROW_REQ = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	typedef struct packed {
		frame_t     fr;
		out_count_t refs;
		status_t    st;
	} reply_t;

	typedef struct packed {
		row_kind_t  kind;
		mode_t      md;
		frame_t     arg;
		cfg_idx_t   idx;
		logic [15:0] reps;
		logic       chk;
		frame_t     ef;
		out_count_t ec;
		status_t    es;
	} dir_row_t;

	localparam reply_t NO_REPLY = '{fr: '0, refs: '0, st: ST_OK};

	localparam int DIR_ROWS = 28;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_REQ, MODE_QUERY,  15'd0,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd0,     8'd0,   ST_OK},
		'{ROW_REQ, MODE_QUERY,  15'd32767, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd0,   ST_OK},
		'{ROW_REQ, MODE_FREE,   15'd5,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd5,     8'd0,
			ST_DOUBLE_FREE},
		'{ROW_REQ, MODE_ALLOC,  15'd0,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd1,   ST_OK},
		'{ROW_REQ, MODE_ALLOC,  15'd12345, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32766, 8'd1,   ST_OK},
		'{ROW_REQ, MODE_ADDREF, 15'd32767, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd2,   ST_OK},
		'{ROW_REQ, MODE_FREE,   15'd32767, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd1,
			ST_REFERENCED},
		'{ROW_REQ, MODE_FREE,   15'd32767, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd0,   ST_OK},
		'{ROW_REQ, MODE_ALLOC,  15'd32767, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd1,   ST_OK},
		'{ROW_REQ, MODE_ADDREF, 15'd100,   REG_LOW_FRAME,  16'd1,   1'b1, 15'd100,   8'd1,   ST_OK},
		'{ROW_REQ, MODE_ADDREF, 15'd100,   REG_LOW_FRAME,  16'd253, 1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_REQ, MODE_ADDREF, 15'd100,   REG_LOW_FRAME,  16'd1,   1'b1, 15'd100,   8'd255, ST_OK},
		'{ROW_REQ, MODE_ADDREF, 15'd100,   REG_LOW_FRAME,  16'd1,   1'b1, 15'd100,   8'd255,
			ST_SATURATED},
		'{ROW_REQ, MODE_FREE,   15'd100,   REG_LOW_FRAME,  16'd1,   1'b1, 15'd100,   8'd254,
			ST_REFERENCED},
		'{ROW_CFG, MODE_QUERY,  15'h1234,  REG_SPARE,      16'd1,   1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_CFG, MODE_QUERY,  15'd16,    REG_LOW_FRAME,  16'd1,   1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_CFG, MODE_QUERY,  15'd19,    REG_HIGH_FRAME, 16'd1,   1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_REQ, MODE_QUERY,  15'd15,    REG_LOW_FRAME,  16'd1,   1'b1, 15'd15,    8'd0,   ST_RANGE},
		'{ROW_REQ, MODE_QUERY,  15'd20,    REG_LOW_FRAME,  16'd1,   1'b1, 15'd20,    8'd0,   ST_RANGE},
		'{ROW_REQ, MODE_FREE,   15'd32767, REG_LOW_FRAME,  16'd1,   1'b1, 15'd32767, 8'd0,   ST_RANGE},
		'{ROW_REQ, MODE_ADDREF, 15'd0,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd0,     8'd0,   ST_RANGE},
		'{ROW_REQ, MODE_ALLOC,  15'd0,     REG_LOW_FRAME,  16'd4,   1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_REQ, MODE_ALLOC,  15'd0,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd0,     8'd0,   ST_OOM},
		'{ROW_REQ, MODE_FREE,   15'd17,    REG_LOW_FRAME,  16'd1,   1'b1, 15'd17,    8'd0,   ST_OK},
		'{ROW_CFG, MODE_QUERY,  15'd40,    REG_LOW_FRAME,  16'd1,   1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_CFG, MODE_QUERY,  15'd50,    REG_HIGH_FRAME, 16'd1,   1'b0, 15'd0,     8'd0,   ST_OK},
		'{ROW_REQ, MODE_ALLOC,  15'd0,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd17,    8'd1,   ST_OK},
		'{ROW_REQ, MODE_ALLOC,  15'd0,     REG_LOW_FRAME,  16'd1,   1'b1, 15'd50,    8'd1,   ST_OK}
	};

	localparam frame_t WIN_LO [PHASES] = '{15'd0, 15'd0, 15'd32767, 15'd1000, 15'd500,
		15'd0, 15'd32752, 15'd21845, 15'd10922, 15'd0};
	localparam frame_t WIN_HI [PHASES] = '{15'd32767, 15'd0, 15'd32767, 15'd1015, 15'd400,
		15'd7, 15'd32767, 15'd21860, 15'd10937, 15'd32767};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	mode_t      mode;
	frame_t     frame;
	logic       out_valid;
	logic       out_ready;
	frame_t     result_frame;
	out_count_t ref_count;
	status_t    status;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_idx_t   cfg_index;
	frame_t     cfg_data;

	// allocator model state
	frame_t stack_mem [FRAME_COUNT];
	count_t counts [FRAME_COUNT];
	int     stack_top;
	int     fresh_ptr;
	int     lo_reg;
	int     hi_reg;

	reply_t replies_due [$];
	frame_t recent_frames [$];
	int     errors;

	refcounted_page_allocator dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic reply_t compute_reply(mode_t m, frame_t f);
		reply_t r;
		int c;
		frame_t got;
		r = '{fr: f, refs: '0, st: ST_OK};
		if (m == MODE_ALLOC) begin
			if (stack_top > 0) begin
				stack_top--;
				got = stack_mem[stack_top];
			end else if (fresh_ptr > lo_reg) begin
				fresh_ptr--;
				got = frame_t'(fresh_ptr);
			end else begin
				r.fr = '0;
				r.st = ST_OOM;
				return r;
			end
			counts[got] = count_t'(1);
			r.fr = got;
			r.refs = out_count_t'(1);
			return r;
		end
		if (f < lo_reg || f > hi_reg) begin
			r.st = ST_RANGE;
			return r;
		end
		c = counts[f];
		case (m)
			MODE_FREE: begin
				if (c == 0) begin
					r.st = ST_DOUBLE_FREE;
				end else begin
					c--;
					counts[f] = count_t'(c);
					r.refs = out_count_t'(c);
					if (c > 0) begin
						r.st = ST_REFERENCED;
					end else if (stack_top < FRAME_COUNT) begin
						stack_mem[stack_top] = f;
						stack_top++;
					end
				end
			end
			MODE_ADDREF: begin
				if (c == COUNT_MAX) begin
					r.st = ST_SATURATED;
				end else begin
					c++;
					counts[f] = count_t'(c);
				end
				r.refs = out_count_t'(c);
			end
			default: r.refs = out_count_t'(c);
		endcase
		return r;
	endfunction

	// leaves in_valid high after the transfer; the caller drives the next cycle
	task automatic send_req(mode_t m, frame_t f, bit typed, reply_t typed_reply);
		reply_t r;
		@(negedge clk);
		in_valid = 1'b1;
		mode = m;
		frame = f;
		do @(posedge clk); while (!in_ready);
		r = compute_reply(m, f);
		if (m == MODE_ALLOC && r.st == ST_OK) begin
			recent_frames.push_back(r.fr);
			if (recent_frames.size() > RECENT_MAX)
				void'(recent_frames.pop_front());
		end
		replies_due.push_back(typed ? typed_reply : r);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, frame_t data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LOW_FRAME) begin
			lo_reg = data;
		end else if (idx == REG_HIGH_FRAME) begin
			hi_reg = data;
			fresh_ptr = ((hi_reg > FRAME_COUNT - 1) ? FRAME_COUNT - 1 : hi_reg) + 1;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic issue_random(int n);
		int burst;
		int gap;
		int pause_at;
		int r;
		mode_t m;
		frame_t f;
		burst = 0;
		pause_at = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				settle();
			if (burst == 0) begin
				gap = $urandom_range(0, 8);
				repeat (gap) begin
					@(negedge clk);
					in_valid = 1'b0;
				end
				burst = $urandom_range(1, 24);
			end
			burst--;
			r = $urandom_range(0, 99);
			m = (r < 35) ? MODE_ALLOC : (r < 70) ? MODE_FREE : (r < 85) ? MODE_ADDREF : MODE_QUERY;
			r = $urandom_range(0, 99);
			if (r < 55 && recent_frames.size() > 0)
				f = recent_frames[$urandom_range(0, recent_frames.size() - 1)];
			else if (r < 85 && lo_reg <= hi_reg)
				f = frame_t'($urandom_range(lo_reg, hi_reg));
			else
				f = frame_t'($urandom);
			send_req(m, f, 1'b0, NO_REPLY);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result with none due, frame %0d count %0d status %0d",
					$time, result_frame, ref_count, status);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (result_frame !== want.fr) begin
					$display("%0t: result_frame expected %0d actual %0d",
						$time, want.fr, result_frame);
					errors++;
				end
				if (ref_count !== want.refs) begin
					$display("%0t: ref_count expected %0d actual %0d",
						$time, want.refs, ref_count);
					errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.st, status);
					errors++;
				end
			end
		end
	end

	// result side stalls
	initial begin
		int seg;
		int pct;
		out_ready = 1'b0;
		forever begin
			seg = $urandom_range(1, 40);
			case ($urandom_range(0, 2))
				0: pct = 0;
				1: pct = 30;
				default: pct = 75;
			endcase
			repeat (seg) begin
				@(negedge clk);
				out_ready = ($urandom_range(0, 99) >= pct);
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("refcounted_page_allocator verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_QUERY;
		frame = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOW_FRAME;
		cfg_data = '0;
		errors = 0;
		lo_reg = LOW_FRAME_RESET;
		hi_reg = HIGH_FRAME_RESET;
		stack_top = 0;
		fresh_ptr = HIGH_FRAME_RESET + 1;
		for (int i = 0; i < FRAME_COUNT; i++)
			counts[i] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				settle();
				write_reg(DIRECTED[i].idx, DIRECTED[i].arg);
			end else begin
				repeat (DIRECTED[i].reps)
					send_req(DIRECTED[i].md, DIRECTED[i].arg, DIRECTED[i].chk,
						'{fr: DIRECTED[i].ef, refs: DIRECTED[i].ec, st: DIRECTED[i].es});
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(REG_LOW_FRAME, WIN_LO[p]);
			write_reg(REG_HIGH_FRAME, WIN_HI[p]);
			issue_random(PHASE_ITEMS);
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0 && replies_due.size() == 0)
			$display("refcounted_page_allocator verification clean");
		else
			$display("refcounted_page_allocator verification failed");
		$finish;
	end

endmodule

// ===== refcounted_page_allocator.f =====
sv/rpa_pkg.sv
sv/rpa_count_mem.sv
sv/rpa_stack_mem.sv
sv/rpa_ctrl.sv
sv/refcounted_page_allocator.sv
bench/tb_refcounted_page_allocator.sv
